// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the PID block.
// Standalone header; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/pidc_pkg.sv -----
// Types and constants of the clamped PID controller.
// Used by pidc_alu, pidc_core and pid_controller_clamped.
package pidc_pkg;

   // default integrator width (Q(n-16).16)
   localparam int INTEGRAL_WIDTH_DEF = 40;

   localparam int DATA_W    = 16;
   localparam int CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MAX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MIN = 3'd4;

   // datapath widths
   localparam int SUM_W      = 56;   // Q.16 sum of the three terms
   localparam int DIFF_W     = 17;   // error minus previous error
   localparam int QUO_W      = 24;   // |diff|*256 and the quotient
   localparam int DERIV_W    = 25;   // signed derivative
   localparam int MUL_A_W    = 17;
   localparam int MUL_B_W    = 33;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int MAG_W      = 64;   // integrator magnitude, widest case
   localparam int KLO_W      = 32;   // low slice of the magnitude
   localparam int KHI_W      = 21;   // next slice; anything above saturates
   localparam int STEP_CNT_W = 5;

   // integral term saturates at 2^52; high partial product limit 2^20
   localparam logic [SUM_W-1:0]  KI_LIMIT  = 56'h10_0000_0000_0000;
   localparam logic [PROD_W-1:0] KHI_LIMIT = 50'd1048576;

   typedef struct packed {
      logic        [DATA_W-1:0] gain_p;
      logic        [DATA_W-1:0] gain_i;
      logic        [DATA_W-1:0] gain_d;
      logic signed [DATA_W-1:0] out_max;
      logic signed [DATA_W-1:0] out_min;
   } cfg_type;

endpackage

// ----- hw/rtl/pidc_alu.sv -----
// Shared arithmetic unit: registered 17x33 signed multiplier and one wide adder.
// Depends on pidc_pkg.
module pidc_alu import pidc_pkg::*; #(
   parameter int ADD_W = 58
) (
   input  logic                     clock,
   input  logic                     mul_go,
   input  logic signed [MUL_A_W-1:0] mul_a,
   input  logic signed [MUL_B_W-1:0] mul_b,
   output logic signed [PROD_W-1:0]  prod,
   input  logic signed [ADD_W-1:0]   add_a,
   input  logic signed [ADD_W-1:0]   add_b,
   input  logic                     add_sub,
   output logic signed [ADD_W-1:0]   add_res
);

   logic signed [PROD_W-1:0] prod_ff;

   // product register, loaded only when a multiply is issued
   always_ff @(posedge clock) begin
      if (mul_go) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   assign prod = prod_ff;

   // add or subtract
   assign add_res = add_sub ? (add_a - add_b) : (add_a + add_b);

endmodule

// ----- hw/rtl/pidc_core.sv -----
// Sequencer and working registers of the PID controller; drives the shared ALU.
// Depends on pidc_pkg and pidc_alu.
module pidc_core import pidc_pkg::*; #(
   parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic signed [DATA_W-1:0] in_error,
   input  logic        [DATA_W-1:0] in_step,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic        [DATA_W-1:0] out_data
);

   localparam int IW    = INTEGRAL_WIDTH;
   localparam int ADD_W = (IW + 2 > SUM_W + 2) ? IW + 2 : SUM_W + 2;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIFF  = 4'd1;
   localparam logic [3:0] S_INTEG = 4'd2;
   localparam logic [3:0] S_PACC  = 4'd3;
   localparam logic [3:0] S_MAG   = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_DSGN  = 4'd6;
   localparam logic [3:0] S_DMUL  = 4'd7;
   localparam logic [3:0] S_DACC  = 4'd8;
   localparam logic [3:0] S_KHI   = 4'd9;
   localparam logic [3:0] S_KLO   = 4'd10;
   localparam logic [3:0] S_KACC  = 4'd11;
   localparam logic [3:0] S_CLAMP = 4'd12;
   localparam logic [3:0] S_DONE  = 4'd13;

   localparam logic signed [IW-1:0] INT_MAX = {1'b0, {(IW-1){1'b1}}};
   localparam logic signed [IW-1:0] INT_MIN = {1'b1, {(IW-1){1'b0}}};

   logic [3:0] state_ff, state_in;
   logic signed [DATA_W-1:0]  err_ff, err_in;
   logic        [DATA_W-1:0]  step_ff, step_in;
   logic signed [DATA_W-1:0]  last_err_ff, last_err_in;
   logic signed [IW-1:0]      integ_ff, integ_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic                      dneg_ff, dneg_in;
   logic        [QUO_W-1:0]   quo_ff, quo_in;
   logic        [DATA_W-1:0]  rem_ff, rem_in;
   logic [STEP_CNT_W-1:0]     cnt_ff, cnt_in;
   logic signed [DERIV_W-1:0] deriv_ff, deriv_in;
   logic        [IW-1:0]      mag_ff, mag_in;
   logic                      ineg_ff, ineg_in;
   logic        [SUM_W-1:0]   kt_ff, kt_in;
   logic                      ksat_ff, ksat_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic        [DATA_W-1:0]  res_ff, res_in;
   logic                      out_valid_ff, out_valid_in;
   logic        [DATA_W-1:0]  out_data_ff, out_data_in;

   // ALU hookup
   logic                      mul_go;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic signed [ADD_W-1:0]   add_a, add_b, add_res;
   logic                      add_sub;

   // helpers
   logic [MAG_W-1:0]         mag64;
   logic [DATA_W:0]          shifted;
   logic [DATA_W-1:0]        dmag;
   logic                     int_ovf;
   logic [SUM_W-1:0]         kclip;
   logic signed [SUM_W-1:0]  hi_bound, lo_bound;
   logic                     round_up;

   pidc_alu #(.ADD_W(ADD_W)) u_alu (
      .clock   (clock),
      .mul_go  (mul_go),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod    (prod),
      .add_a   (add_a),
      .add_b   (add_b),
      .add_sub (add_sub),
      .add_res (add_res)
   );

   assign mag64    = MAG_W'(mag_ff);
   assign shifted  = {rem_ff, quo_ff[QUO_W-1]};
   assign dmag     = diff_ff[DIFF_W-1] ? add_res[DATA_W-1:0] : diff_ff[DATA_W-1:0];
   assign int_ovf  = (add_res[ADD_W-1:IW-1] != '0) && (add_res[ADD_W-1:IW-1] != '1);
   assign kclip    = (ksat_ff || (kt_ff > KI_LIMIT)) ? KI_LIMIT : kt_ff;
   assign hi_bound = {{(SUM_W-32){cfg.out_max[DATA_W-1]}}, cfg.out_max, 16'h0000};
   assign lo_bound = {{(SUM_W-32){cfg.out_min[DATA_W-1]}}, cfg.out_min, 16'h0000};
   assign round_up = sum_ff[SUM_W-1] && (sum_ff[15:0] != 16'h0000);

   // sequencer and datapath control
   always_comb begin
      state_in     = state_ff;
      err_in       = err_ff;
      step_in      = step_ff;
      last_err_in  = last_err_ff;
      integ_in     = integ_ff;
      diff_in      = diff_ff;
      dneg_in      = dneg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      deriv_in     = deriv_ff;
      mag_in       = mag_ff;
      ineg_in      = ineg_ff;
      kt_in        = kt_ff;
      ksat_in      = ksat_ff;
      sum_in       = sum_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      mul_go       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      add_a        = '0;
      add_b        = '0;
      add_sub      = 1'b0;

      // result taken downstream
      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               err_in   = in_error;
               step_in  = in_step;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            // diff = e - last_e ; issue e * dt
            add_a    = ADD_W'(err_ff);
            add_b    = ADD_W'(last_err_ff);
            add_sub  = 1'b1;
            diff_in  = add_res[DIFF_W-1:0];
            mul_go   = 1'b1;
            mul_a    = signed'({1'b0, step_ff});
            mul_b    = MUL_B_W'(err_ff);
            state_in = S_INTEG;
         end
         S_INTEG: begin
            // saturating integrator update ; issue Kp * e
            add_a       = ADD_W'(integ_ff);
            add_b       = ADD_W'(prod);
            integ_in    = int_ovf ? (add_res[ADD_W-1] ? INT_MIN : INT_MAX)
                                  : add_res[IW-1:0];
            last_err_in = err_ff;
            mul_go      = 1'b1;
            mul_a       = signed'({1'b0, cfg.gain_p});
            mul_b       = MUL_B_W'(err_ff);
            state_in    = S_PACC;
         end
         S_PACC: begin
            // P term into the sum ; |diff| for the divider
            sum_in   = SUM_W'(prod) <<< 8;
            add_b    = ADD_W'(diff_ff);
            add_sub  = 1'b1;
            dneg_in  = diff_ff[DIFF_W-1];
            quo_in   = (step_ff == '0) ? '0 : {dmag, 8'h00};
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_MAG;
         end
         S_MAG: begin
            // integrator magnitude and sign
            add_b    = ADD_W'(integ_ff);
            add_sub  = 1'b1;
            ineg_in  = integ_ff[IW-1];
            mag_in   = integ_ff[IW-1] ? add_res[IW-1:0] : $unsigned(integ_ff);
            state_in = (step_ff == '0) ? S_DSGN : S_DIV;
         end
         S_DIV: begin
            // one restoring divide step per cycle
            add_a   = ADD_W'(shifted);
            add_b   = ADD_W'(step_ff);
            add_sub = 1'b1;
            if (!add_res[ADD_W-1]) begin
               rem_in = add_res[DATA_W-1:0];
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[DATA_W-1:0];
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_CNT_W'(QUO_W - 1)) begin
               state_in = S_DSGN;
            end
         end
         S_DSGN: begin
            // apply sign to the quotient
            add_b    = ADD_W'(quo_ff);
            add_sub  = dneg_ff;
            deriv_in = add_res[DERIV_W-1:0];
            state_in = S_DMUL;
         end
         S_DMUL: begin
            mul_go   = 1'b1;
            mul_a    = signed'({1'b0, cfg.gain_d});
            mul_b    = MUL_B_W'(deriv_ff);
            state_in = S_DACC;
         end
         S_DACC: begin
            // D term into the sum ; issue Ki * magnitude high slice
            add_a    = ADD_W'(sum_ff);
            add_b    = ADD_W'(prod) <<< 8;
            sum_in   = add_res[SUM_W-1:0];
            ksat_in  = (cfg.gain_i != '0) && (mag64[MAG_W-1:KLO_W+KHI_W] != '0);
            mul_go   = 1'b1;
            mul_a    = signed'({1'b0, cfg.gain_i});
            mul_b    = MUL_B_W'(mag64[KLO_W+KHI_W-1:KLO_W]);
            state_in = S_KHI;
         end
         S_KHI: begin
            // high partial product ; issue Ki * low slice
            if ($unsigned(prod) > KHI_LIMIT) begin
               ksat_in = 1'b1;
            end
            kt_in    = SUM_W'({prod[KHI_W-1:0], {KLO_W{1'b0}}});
            mul_go   = 1'b1;
            mul_a    = signed'({1'b0, cfg.gain_i});
            mul_b    = MUL_B_W'(mag64[KLO_W-1:0]);
            state_in = S_KLO;
         end
         S_KLO: begin
            add_a    = ADD_W'(kt_ff);
            add_b    = ADD_W'(prod);
            kt_in    = add_res[SUM_W-1:0];
            state_in = S_KACC;
         end
         S_KACC: begin
            // saturated I term, signed by the integrator
            add_a    = ADD_W'(sum_ff);
            add_b    = ADD_W'(kclip);
            add_sub  = ineg_ff;
            sum_in   = add_res[SUM_W-1:0];
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            // max checked first, then min, else truncate toward zero
            add_a = ADD_W'(sum_ff >>> 16);
            add_b = ADD_W'(round_up);
            if (sum_ff > hi_bound) begin
               res_in = cfg.out_max;
            end else if (sum_ff < lo_bound) begin
               res_in = cfg.out_min;
            end else begin
               res_in = add_res[DATA_W-1:0];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in = 1'b1;
               out_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         last_err_ff  <= '0;
         integ_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         last_err_ff  <= last_err_in;
         integ_ff     <= integ_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      step_ff     <= step_in;
      diff_ff     <= diff_in;
      dneg_ff     <= dneg_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      deriv_ff    <= deriv_in;
      mag_ff      <= mag_in;
      ineg_ff     <= ineg_in;
      kt_ff       <= kt_in;
      ksat_ff     <= ksat_in;
      sum_ff      <= sum_in;
      res_ff      <= res_in;
      out_data_ff <= out_data_in;
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ----- hw/rtl/pid_controller_clamped.sv -----
// An accepted item runs through the sequencer states, with the 24-step restoring divide
// for the derivative (skipped when step_time is zero) on the single shared adder; no new
// item is taken until the result has moved to the output register.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active high): gains 0, out_max 32767, out_min -32768,
// previous error and integrator cleared, no result pending.
`include "assert_macros.svh"

module pid_controller_clamped import pidc_pkg::*; #(
   parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // input items
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // [15:0] error_sample, [31:16] step_time
   // result items
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_W-1:0]    rsp_tdata,   // [15:0] control_out
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data
);

   cfg_type cfg_ff, cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GAIN_P:  cfg_in.gain_p  = csr_data;
            CSR_GAIN_I:  cfg_in.gain_i  = csr_data;
            CSR_GAIN_D:  cfg_in.gain_d  = csr_data;
            CSR_OUT_MAX: cfg_in.out_max = csr_data;
            CSR_OUT_MIN: cfg_in.out_min = csr_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p  <= '0;
         cfg_ff.gain_i  <= '0;
         cfg_ff.gain_d  <= '0;
         cfg_ff.out_max <= 16'sh7FFF;
         cfg_ff.out_min <= 16'sh8000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   pidc_core #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_error  (req_tdata[15:0]),
      .in_step   (req_tdata[31:16]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   // checks
   `ASSERT_PROP(a_busy_after_accept, clock, reset,
      (req_tvalid && req_tready) |=> !req_tready,
      "input still ready after an item was taken")
   `ASSERT_PROP(a_gain_p_write, clock, reset,
      (csr_valid && csr_ready && csr_index == CSR_GAIN_P) |=>
         (cfg_ff.gain_p == $past(csr_data)),
      "gain_p write lost")
   `ASSERT_NEVER(a_cfg_reset_max, clock, reset,
      $fell(reset) && (cfg_ff.out_max != 16'sh7FFF),
      "out_max not at reset value")

endmodule

// ----- tb/sv/pidc_checker.sv -----
// Output checker for the clamped PID controller: tracks register writes and items
// on the ports, predicts every control output and compares it with the block.
// Depends on pidc_pkg for widths, register indexes and the register layout.
module pidc_checker import pidc_pkg::*; #(
   parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [31:0]          req_tdata,   // [15:0] error_sample, [31:16] step_time
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [DATA_W-1:0]    rsp_tdata,   // [15:0] control_out
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data,
   output int                   error_count,
   output int                   outstanding,
   output int                   outputs_checked,
   output int                   clamped_high,
   output int                   clamped_low,
   output int                   integrator_at_limit
);
   timeunit 1ns;
   timeprecision 1ps;

   // integrator limits (Q.16) and cap on the integral term (Q.16)
   localparam longint INTEG_MAX = (longint'(1) <<< (INTEGRAL_WIDTH - 1)) - 1;
   localparam longint INTEG_MIN = -INTEG_MAX - 1;
   localparam longint KI_CAP    = longint'(1) <<< 52;

   typedef struct {
      logic signed [DATA_W-1:0] control_out;
      logic signed [DATA_W-1:0] error_sample;
      logic        [DATA_W-1:0] step_time;
   } control_expect_type;

   control_expect_type       pending_outputs[$];
   cfg_type                  ctrl_regs;
   logic signed [DATA_W-1:0] prev_error;
   longint                   integrator;
   int n_errors, n_checked, n_high, n_low, n_limit;

   // one controller step: updates the stored error and integrator, returns the output
   function automatic logic signed [DATA_W-1:0] next_control(
      input logic signed [DATA_W-1:0] err,
      input logic        [DATA_W-1:0] dt
   );
      longint rate, ki_part, mag, sum, upper, lower;
      logic signed [DATA_W-1:0] result;
      rate = 0;
      if (dt != 0)
         rate = (longint'(err) - longint'(prev_error)) * 256 / longint'(dt);
      prev_error = err;

      // saturating integrator, Q.16
      integrator = integrator + longint'(err) * longint'(dt);
      if (integrator > INTEG_MAX)
         integrator = INTEG_MAX;
      else if (integrator < INTEG_MIN)
         integrator = INTEG_MIN;
      if (integrator == INTEG_MAX || integrator == INTEG_MIN)
         n_limit++;

      // integral term on the magnitude, capped, sign put back afterwards
      mag     = (integrator < 0) ? -integrator : integrator;
      ki_part = mag * longint'(ctrl_regs.gain_i);
      if (ki_part > KI_CAP)
         ki_part = KI_CAP;
      if (integrator < 0)
         ki_part = -ki_part;

      // exact sum in Q.16, upper bound wins when the bounds are crossed
      sum = longint'(ctrl_regs.gain_p) * longint'(err) * 256
          + longint'(ctrl_regs.gain_d) * rate * 256
          + ki_part;
      upper = longint'($signed(ctrl_regs.out_max)) * 65536;
      lower = longint'($signed(ctrl_regs.out_min)) * 65536;
      if (sum > upper) begin
         result = ctrl_regs.out_max;
         n_high++;
      end else if (sum < lower) begin
         result = ctrl_regs.out_min;
         n_low++;
      end else begin
         result = DATA_W'(sum / 65536);
      end
      return result;
   endfunction

   always @(posedge clock) begin
      control_expect_type want;
      logic signed [DATA_W-1:0] got;
      if (reset) begin
         ctrl_regs         = '0;
         ctrl_regs.out_max = 16'sh7FFF;
         ctrl_regs.out_min = 16'sh8000;
         prev_error        = '0;
         integrator        = 0;
         pending_outputs.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GAIN_P:  ctrl_regs.gain_p  = csr_data;
               CSR_GAIN_I:  ctrl_regs.gain_i  = csr_data;
               CSR_GAIN_D:  ctrl_regs.gain_d  = csr_data;
               CSR_OUT_MAX: ctrl_regs.out_max = csr_data;
               CSR_OUT_MIN: ctrl_regs.out_min = csr_data;
               default: ;
            endcase
         end
         // accepted item: predict its output
         if (req_tvalid && req_tready) begin
            want.error_sample = req_tdata[15:0];
            want.step_time    = req_tdata[31:16];
            want.control_out  = next_control(want.error_sample, want.step_time);
            pending_outputs.push_back(want);
         end
         // accepted result: compare with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_outputs.size() == 0) begin
               n_errors++;
               $display("%0t: unexpected result, expected none, got control_out %0d",
                        $time, got);
            end else begin
               want = pending_outputs.pop_front();
               n_checked++;
               if (got !== want.control_out) begin
                  n_errors++;
                  $display("%0t: control_out mismatch (error %0d, step %0d): expected %0d, got %0d",
                           $time, want.error_sample, want.step_time,
                           want.control_out, got);
               end
            end
         end
      end
      error_count         <= n_errors;
      outstanding         <= pending_outputs.size();
      outputs_checked     <= n_checked;
      clamped_high        <= n_high;
      clamped_low         <= n_low;
      integrator_at_limit <= n_limit;
   end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the clamped PID controller bench: clock, reset, item and register
// stimulus with random idling, watchdog and verdict.
// Depends on pidc_pkg, pid_controller_clamped and pidc_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pidc_pkg::*;

   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 60;
   localparam int WINDUP_ITEMS    = 310;
   localparam int HOLD_CYCLES     = 400;
   localparam int IDLE_LIMIT      = 5000;
   localparam int SETTLE_CYCLES   = 60;

   typedef enum {MIX_GENERAL, MIX_WINDUP_POS, MIX_WINDUP_NEG} item_mix_type;
   typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_RHYTHM} ready_mode_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [31:0]          req_tdata;   // [15:0] error_sample, [31:16] step_time
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [DATA_W-1:0]    rsp_tdata;   // [15:0] control_out
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_data;

   int error_count, outstanding, outputs_checked;
   int clamped_high, clamped_low, integrator_at_limit;
   int hold_requests;
   int items_sent;
   int reg_writes;

   pid_controller_clamped dut (.*);

   pidc_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---- register writes -------------------------------------------------

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      reg_writes++;
   endtask

   // all five registers, optionally followed by writes to the unused indexes
   task automatic load_settings(input logic [15:0] kp, ki, kd, hi, lo, input bit stray);
      write_reg(CSR_GAIN_P, kp);
      write_reg(CSR_GAIN_I, ki);
      write_reg(CSR_GAIN_D, kd);
      write_reg(CSR_OUT_MAX, hi);
      write_reg(CSR_OUT_MIN, lo);
      if (stray)
         for (int idx = int'(CSR_OUT_MIN) + 1; idx < 2 ** CSR_IDX_W; idx++)
            write_reg(CSR_IDX_W'(idx), 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   // ---- items -------------------------------------------------------------

   task automatic offer_item(input logic [15:0] err, input logic [15:0] dt);
      req_tvalid <= 1'b1;
      req_tdata  <= {dt, err};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // stop offering and wait for every predicted output to come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [31:0] random_item(input item_mix_type mix);
      logic [15:0] err, dt;
      case (mix)
         MIX_WINDUP_POS: begin
            err = 16'h7FFF - 16'($urandom_range(0, 255));
            dt  = 16'hFFFF - 16'($urandom_range(0, 255));
         end
         MIX_WINDUP_NEG: begin
            err = 16'h8000 + 16'($urandom_range(0, 255));
            dt  = 16'hFFFF - 16'($urandom_range(0, 255));
         end
         default: begin
            case ($urandom_range(0, 7))
               0:       err = 16'h7FFF;
               1:       err = 16'h8000;
               2, 3:    err = 16'($urandom_range(0, 511)) - 16'd256;
               default: err = 16'($urandom);
            endcase
            case ($urandom_range(0, 7))
               0:       dt = '0;
               1:       dt = 16'($urandom_range(1, 16));
               2:       dt = 16'hFFFF;
               default: dt = 16'($urandom);
            endcase
         end
      endcase
      return {dt, err};
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 16'h0200));
         default: return 16'($urandom);
      endcase
   endfunction

   // {out_max, out_min}: full range, ordered, crossed, equal or narrow
   function automatic logic [31:0] pick_bounds();
      logic signed [15:0] a, b;
      a = 16'($urandom);
      b = 16'($urandom);
      case ($urandom_range(0, 4))
         0:       return {16'h7FFF, 16'h8000};
         1:       return (a >= b) ? {a, b} : {b, a};
         2:       return (a >= b) ? {b, a} : {a, b};
         3:       return {a, a};
         default: begin
            a = 16'($urandom_range(0, 16'h0800));
            return {a, -a};
         end
      endcase
   endfunction

   // items in bursts with random gaps; the first 'steady' items go back to back
   task automatic run_items(input int count, input item_mix_type mix, input int steady);
      logic [15:0]  err, dt;
      item_mix_type this_mix;
      int           burst;
      burst = 0;
      for (int n = 0; n < count; n++) begin
         if (n >= steady && burst == 0) begin
            burst = $urandom_range(1, 24);
            case ($urandom_range(0, 15))
               0:             wait_drained();
               1, 2, 3, 4, 5: ;
               default: begin
                  req_tvalid <= 1'b0;
                  repeat ($urandom_range(1, 50)) @(posedge clock);
               end
            endcase
         end
         if (burst > 0)
            burst--;
         // the odd unrelated item in a wind-up run
         this_mix = (mix != MIX_GENERAL && $urandom_range(0, 15) == 0) ? MIX_GENERAL : mix;
         {dt, err} = random_item(this_mix);
         offer_item(err, dt);
      end
   endtask

   // ---- stimulus ------------------------------------------------------------

   initial begin
      logic [15:0] hi, lo;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // gains are zero out of reset, so the output is zero
      offer_item(16'h1234, 16'h0100);
      wait_drained();

      // field extremes and zero step, full clamp range
      load_settings(16'h0100, 16'h0001, 16'h0100, 16'h7FFF, 16'h8000, 1'b1);
      offer_item(16'h7FFF, 16'h0000);
      offer_item(16'h8000, 16'h0001);
      offer_item(16'h7FFF, 16'h0001);
      offer_item(16'h8000, 16'hFFFF);
      offer_item(16'h7FFF, 16'hFFFF);
      offer_item(16'h0000, 16'h0000);
      offer_item(16'h0100, 16'h0100);
      offer_item(16'hFFFF, 16'hFFFF);
      offer_item(16'h5555, 16'hAAAA);
      offer_item(16'hAAAA, 16'h5555);
      wait_drained();

      // narrow bounds: above, below and inside
      load_settings(16'h0100, 16'h0000, 16'h0000, 16'h0200, 16'hFE00, 1'b0);
      offer_item(16'h0400, 16'h0000);
      offer_item(16'hFC00, 16'h0000);
      offer_item(16'h0080, 16'h0000);
      wait_drained();

      // crossed bounds: anything above the upper bound gives the upper bound
      load_settings(16'h0100, 16'h0000, 16'h0000, 16'hFF00, 16'h0100, 1'b0);
      offer_item(16'h7FFF, 16'h0000);
      offer_item(16'h8000, 16'h0000);
      offer_item(16'h0000, 16'h0000);
      wait_drained();

      // largest gains, full range
      load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 1'b0);
      offer_item(16'h7FFF, 16'h0001);
      offer_item(16'h8000, 16'h0001);
      wait_drained();

      // largest gains, bounds at opposite extremes
      load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b0);
      offer_item(16'h7FFF, 16'h0001);
      offer_item(16'h8000, 16'h0001);
      wait_drained();

      // random settings and items; a long receiver hold-off in the second phase
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         {hi, lo} = pick_bounds();
         load_settings(pick_gain(),
                       $urandom_range(0, 1) ? 16'($urandom_range(0, 8)) : pick_gain(),
                       pick_gain(), hi, lo, 1'($urandom_range(0, 1)));
         if (phase == 1)
            hold_requests <= hold_requests + 1;
         run_items(ITEMS_PER_PHASE, MIX_GENERAL, (phase == 1) ? 20 : 0);
         wait_drained();
      end

      // drive the integrator into one of its limits, with a hold-off at the start
      load_settings(16'($urandom_range(0, 16'h0100)), 16'($urandom_range(1, 16'hFFFF)),
                    16'($urandom_range(0, 16'h0100)), 16'h7FFF, 16'h8000, 1'b0);
      hold_requests <= hold_requests + 1;
      run_items(WINDUP_ITEMS, $urandom_range(0, 1) ? MIX_WINDUP_POS : MIX_WINDUP_NEG, 20);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d items and %0d register writes; %0d outputs checked.",
               items_sent, reg_writes, outputs_checked);
      $display("Outputs clamped high %0d, low %0d; integrator at its limit on %0d items.",
               clamped_high, clamped_low, integrator_at_limit);
      if (error_count == 0 && outstanding == 0)
         $display("[pid_controller_clamped] OK");
      else
         $display("[pid_controller_clamped] ERROR");
      $finish;
   end

   // ---- receiver: changing ready patterns, long hold-off on request ------

   initial begin
      ready_mode_type mode;
      int             left, tick, holds_done;
      rsp_tready <= 1'b0;
      mode       = READY_ALWAYS;
      left       = 0;
      tick       = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end
         if (left == 0) begin
            mode = ready_mode_type'($urandom_range(0, 3));
            left = $urandom_range(20, 300);
         end
         left--;
         tick++;
         case (mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:      rsp_tready <= ((tick % 7) < 3);
         endcase
      end
   end

   // ---- watchdog: nothing accepted on any channel for too long ------------

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
               || (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("Timeout: nothing accepted for %0d cycles, %0d outputs still due",
               IDLE_LIMIT, outstanding);
      $display("[pid_controller_clamped] ERROR");
      $finish;
   end

endmodule
